### sv/resting_limit_order_trigger_defines.svh
// Assertion macros for the resting limit order trigger.
// Included by the top level; define ASSERT_OFF to compile them away.
`ifndef RESTING_LIMIT_ORDER_TRIGGER_DEFINES_SVH
`define RESTING_LIMIT_ORDER_TRIGGER_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain property, sampled on the rising clock, off during reset.
`define RLOT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RLOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define RLOT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RLOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/rlot_pkg.sv
// Shared types and constants of the resting limit order trigger.
// Used by rlot_cell and resting_limit_order_trigger; no dependencies.
package rlot_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam int MAX_RESULTS         = 32;
  localparam int NW                  = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_ORDER  = 1'b0;
  localparam logic KIND_QUOTE  = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;
  localparam logic TYPE_MARKET = 1'b0;
  localparam logic TYPE_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    EXEC_ACCEPTED = 2'd0,
    EXEC_FILLED   = 2'd1,
    EXEC_REJECTED = 2'd2
  } exec_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // One resting order.
  typedef struct packed {
    logic [31:0] order_id;
    logic [15:0] symbol;
    logic        side;
    logic [31:0] limit;
    logic [31:0] qty;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

  typedef struct packed {
    logic [31:0] order_id;
    logic [15:0] symbol;
    logic        side;
    exec_kind_e  kind;
    logic [31:0] last_qty;
    logic [31:0] last_price;
    logic [31:0] leaves_qty;
    logic [31:0] cum_qty;
    logic        last_of_run;
  } report_t;

endpackage

### sv/resting_limit_order_trigger.sv
// Resting limit order trigger: top level with control and the cell chain.
// Depends on rlot_pkg, rlot_cell and resting_limit_order_trigger_defines.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid_i/in_stall_o | kind .. ask (order or quote)
//  out     | output    | out_valid_o/out_stall_i | report_order_id .. last_of_run
//
// An order is accepted in ST_IDLE; its single report goes to the output register.
// A quote steps through accept, a scan step for each resting order as cell 0 is
// examined and the chain shifts toward it, a step to close the scan, and a flush.
// Each fill after the first, and the flush, wait for the output register to free up.
// New requests stall during a quote and while a stalled report holds the output.
// Reset clears the count and control only; unwritten cells are never read.
`include "resting_limit_order_trigger_defines.svh"

module resting_limit_order_trigger #(
  parameter int TABLE_DEPTH = rlot_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] order_id_i,
  input  logic [15:0] symbol_id_i,
  input  logic        side_i,
  input  logic        order_type_i,
  input  logic [31:0] price_i,
  input  logic [31:0] quantity_i,
  input  logic [31:0] bid_i,
  input  logic [31:0] ask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] report_order_id_o,
  output logic [15:0] report_symbol_o,
  output logic        report_side_o,
  output logic [1:0]  exec_kind_o,
  output logic [31:0] last_qty_o,
  output logic [31:0] last_price_o,
  output logic [31:0] leaves_qty_o,
  output logic [31:0] cum_qty_o,
  output logic [31:0] avg_price_o,
  output logic        last_of_run_o
);
  import rlot_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] count_m1;
  logic [NW-1:0] n_q, n_d;
  logic          pend_valid_q, pend_valid_d;
  report_t       pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  report_t       out_q, out_d;
  logic          out_load, out_free;
  logic [15:0]   qsym_q, qsym_d;
  logic [31:0]   qbid_q, qbid_d;
  logic [31:0]   qask_q, qask_d;

  cell_ctl_t     ctl;
  logic [IW-1:0] wr_idx;
  entry_t        wr_data;
  entry_t        cells [TABLE_DEPTH];
  entry_t        head;
  entry_t        new_entry;

  logic          in_acc;
  logic          buy_hit, sell_hit, fill;
  logic [31:0]   fill_price;
  report_t       fill_rpt;

  // Cell chain: cell 0 is the oldest order.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign nbr = cells[i+1];
    end else begin : g_end
      assign nbr = cells[0];
    end
    rlot_cell #(
      .IDX(i),
      .IW (IW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .wr_idx_i (wr_idx),
      .wr_data_i(wr_data),
      .nbr_i    (nbr),
      .entry_o  (cells[i])
    );
  end

  assign head       = cells[0];
  assign count_m1   = count_q - CW'(1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign new_entry.order_id = order_id_i;
  assign new_entry.symbol   = symbol_id_i;
  assign new_entry.side     = side_i;
  assign new_entry.limit    = price_i;
  assign new_entry.qty      = quantity_i;

  assign buy_hit    = (qask_q != 32'd0) && (qask_q <= head.limit);
  assign sell_hit   = (qbid_q != 32'd0) && (qbid_q >= head.limit);
  assign fill       = (n_q < NW'(MAX_RESULTS)) && (head.symbol == qsym_q) &&
                      ((head.side == SIDE_BUY) ? buy_hit : sell_hit);
  assign fill_price = (head.side == SIDE_BUY) ? qask_q : qbid_q;

  assign fill_rpt.order_id    = head.order_id;
  assign fill_rpt.symbol      = head.symbol;
  assign fill_rpt.side        = head.side;
  assign fill_rpt.kind        = EXEC_FILLED;
  assign fill_rpt.last_qty    = head.qty;
  assign fill_rpt.last_price  = fill_price;
  assign fill_rpt.leaves_qty  = 32'd0;
  assign fill_rpt.cum_qty     = head.qty;
  assign fill_rpt.last_of_run = 1'b0;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    qsym_d       = qsym_q;
    qbid_d       = qbid_q;
    qask_d       = qask_q;
    out_load     = 1'b0;
    out_d        = out_q;
    ctl          = '0;
    wr_idx       = count_q[IW-1:0];
    wr_data      = head;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_ORDER) begin
            out_load              = 1'b1;
            out_d.order_id        = order_id_i;
            out_d.symbol          = symbol_id_i;
            out_d.side            = side_i;
            out_d.last_of_run     = 1'b1;
            priority if (order_type_i == TYPE_MARKET) begin
              out_d.kind       = EXEC_FILLED;
              out_d.last_qty   = quantity_i;
              out_d.last_price = price_i;
              out_d.leaves_qty = 32'd0;
              out_d.cum_qty    = quantity_i;
            end else if (count_q == CW'(TABLE_DEPTH)) begin
              out_d.kind       = EXEC_REJECTED;
              out_d.last_qty   = 32'd0;
              out_d.last_price = 32'd0;
              out_d.leaves_qty = 32'd0;
              out_d.cum_qty    = 32'd0;
            end else begin
              // Append behind the youngest resting order.
              ctl.wr           = 1'b1;
              wr_data          = new_entry;
              count_d          = count_q + CW'(1);
              out_d.kind       = EXEC_ACCEPTED;
              out_d.last_qty   = 32'd0;
              out_d.last_price = 32'd0;
              out_d.leaves_qty = quantity_i;
              out_d.cum_qty    = 32'd0;
            end
          end else begin
            qsym_d       = symbol_id_i;
            qbid_d       = bid_i;
            qask_d       = ask_i;
            rem_d        = count_q;
            n_d          = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rem_q == '0) begin
          state_d = ST_FLUSH;
        end else if (fill) begin
          // Hold the step while an earlier fill cannot move on.
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_load = 1'b1;
              out_d    = pend_q;
            end
            pend_d       = fill_rpt;
            pend_valid_d = 1'b1;
            n_d          = n_q + NW'(1);
            count_d      = count_m1;
            rem_d        = rem_q - CW'(1);
            ctl.shift    = 1'b1;
          end
        end else begin
          // Keep: rewrite the head just behind the survivors.
          ctl.shift = 1'b1;
          ctl.wr    = 1'b1;
          wr_idx    = count_m1[IW-1:0];
          wr_data   = head;
          rem_d     = rem_q - CW'(1);
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load          = 1'b1;
          out_d             = pend_q;
          out_d.last_of_run = 1'b1;
          pend_valid_d      = 1'b0;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      rem_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rem_q        <= rem_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    qsym_q <= qsym_d;
    qbid_q <= qbid_d;
    qask_q <= qask_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign report_order_id_o = out_q.order_id;
  assign report_symbol_o   = out_q.symbol;
  assign report_side_o     = out_q.side;
  assign exec_kind_o       = out_q.kind;
  assign last_qty_o        = out_q.last_qty;
  assign last_price_o      = out_q.last_price;
  assign leaves_qty_o      = out_q.leaves_qty;
  assign cum_qty_o         = out_q.cum_qty;
  assign avg_price_o       = out_q.last_price;
  assign last_of_run_o     = out_q.last_of_run;

  `RLOT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(TABLE_DEPTH), "count over depth")
  `RLOT_ASSERT(a_fill_bound, clk_i, rst_ni, n_q <= NW'(MAX_RESULTS), "fill count over limit")
  `RLOT_ASSERT_IMP(a_pend_idle, clk_i, rst_ni, state_q == ST_IDLE, !pend_valid_q,
                   "pending fill left behind in idle")
  `RLOT_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, state_q == ST_SCAN, rem_q <= count_q,
                   "scan count beyond table")

endmodule

### sv/rlot_cell.sv
// One slot of the resting order chain: holds an entry, takes its upper
// neighbor on a shift, or the broadcast entry when its index is addressed.
// Depends on rlot_pkg.
module rlot_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  logic                clk_i,
  input  rlot_pkg::cell_ctl_t ctl_i,
  input  logic [IW-1:0]       wr_idx_i,
  input  rlot_pkg::entry_t    wr_data_i,
  input  rlot_pkg::entry_t    nbr_i,
  output rlot_pkg::entry_t    entry_o
);
  import rlot_pkg::*;

  entry_t entry_q;
  entry_t entry_d;
  logic   hit;

  assign hit = ctl_i.wr && (wr_idx_i == IW'(IDX));

  always_comb begin
    priority if (hit) begin
      entry_d = wr_data_i;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### test/resting_limit_order_trigger_tb.sv
// Self-checking testbench for the resting limit order trigger.
// Depends on rlot_pkg and resting_limit_order_trigger; predicts every report in-line.
`timescale 1ns / 100ps

module resting_limit_order_trigger_tb;
  import rlot_pkg::*;

  localparam int BOOK_DEPTH   = TABLE_DEPTH_DEFAULT;
  localparam int FEED_TARGET  = 410;
  localparam int SETTLE_TICKS = 64;
  localparam int CYCLE_LIMIT  = 800000;

  typedef struct packed {
    logic        pause;
    logic        kind;
    logic [31:0] order_id;
    logic [15:0] symbol;
    logic        side;
    logic        otype;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] bid;
    logic [31:0] ask;
  } feed_item_t;

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_RUNS
  } sink_mode_e;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       feed_valid  = 1'b0;
  logic       sink_stall  = 1'b0;
  feed_item_t drive_item  = '0;

  logic        in_stall;
  logic        report_valid;
  logic [31:0] rpt_order_id;
  logic [15:0] rpt_symbol;
  logic        rpt_side;
  logic [1:0]  rpt_exec_kind;
  logic [31:0] rpt_last_qty;
  logic [31:0] rpt_last_price;
  logic [31:0] rpt_leaves_qty;
  logic [31:0] rpt_cum_qty;
  logic [31:0] rpt_avg_price;
  logic        rpt_last_of_run;

  feed_item_t pending_feed[$];
  report_t    expected_reports[$];
  entry_t     resting_book[$];
  logic [15:0] stray_symbols[$];

  int feed_total;
  int mismatches;
  int cycle_count;
  int n_market, n_limit, n_quotes, n_acks, n_fills, n_rejects;
  int deepest_book, widest_sweep;

  resting_limit_order_trigger DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (feed_valid),
    .in_stall_o        (in_stall),
    .kind_i            (drive_item.kind),
    .order_id_i        (drive_item.order_id),
    .symbol_id_i       (drive_item.symbol),
    .side_i            (drive_item.side),
    .order_type_i      (drive_item.otype),
    .price_i           (drive_item.price),
    .quantity_i        (drive_item.qty),
    .bid_i             (drive_item.bid),
    .ask_i             (drive_item.ask),
    .out_valid_o       (report_valid),
    .out_stall_i       (sink_stall),
    .report_order_id_o (rpt_order_id),
    .report_symbol_o   (rpt_symbol),
    .report_side_o     (rpt_side),
    .exec_kind_o       (rpt_exec_kind),
    .last_qty_o        (rpt_last_qty),
    .last_price_o      (rpt_last_price),
    .leaves_qty_o      (rpt_leaves_qty),
    .cum_qty_o         (rpt_cum_qty),
    .avg_price_o       (rpt_avg_price),
    .last_of_run_o     (rpt_last_of_run)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Order book predictor: update the book and queue the reports one request causes.
  function automatic void book_step(feed_item_t it);
    entry_t  kept[$];
    report_t fills[$];
    report_t rpt;
    entry_t  ent;
    logic    hit;
    logic [31:0] fill_px;
    rpt = '0;
    rpt.order_id    = it.order_id;
    rpt.symbol      = it.symbol;
    rpt.side        = it.side;
    rpt.last_of_run = 1'b1;
    if (it.kind == KIND_ORDER) begin
      if (it.otype == TYPE_MARKET) begin
        n_market++;
        n_fills++;
        rpt.kind       = EXEC_FILLED;
        rpt.last_qty   = it.qty;
        rpt.last_price = it.price;
        rpt.cum_qty    = it.qty;
      end else begin
        n_limit++;
        if (resting_book.size() >= BOOK_DEPTH) begin
          n_rejects++;
          rpt.kind = EXEC_REJECTED;
        end else begin
          n_acks++;
          ent.order_id = it.order_id;
          ent.symbol   = it.symbol;
          ent.side     = it.side;
          ent.limit    = it.price;
          ent.qty      = it.qty;
          resting_book.insert(resting_book.size(), ent);
          if (resting_book.size() > deepest_book) deepest_book = resting_book.size();
          rpt.kind       = EXEC_ACCEPTED;
          rpt.leaves_qty = it.qty;
        end
      end
      expected_reports.insert(expected_reports.size(), rpt);
      return;
    end
    n_quotes++;
    // Scan oldest first; survivors keep their relative order.
    foreach (resting_book[i]) begin
      hit     = 1'b0;
      fill_px = '0;
      if (fills.size() < MAX_RESULTS && resting_book[i].symbol == it.symbol) begin
        if (resting_book[i].side == SIDE_BUY) begin
          if (it.ask != 0 && it.ask <= resting_book[i].limit) begin
            hit     = 1'b1;
            fill_px = it.ask;
          end
        end else if (it.bid != 0 && it.bid >= resting_book[i].limit) begin
          hit     = 1'b1;
          fill_px = it.bid;
        end
      end
      if (hit) begin
        rpt             = '0;
        rpt.order_id    = resting_book[i].order_id;
        rpt.symbol      = resting_book[i].symbol;
        rpt.side        = resting_book[i].side;
        rpt.kind        = EXEC_FILLED;
        rpt.last_qty    = resting_book[i].qty;
        rpt.last_price  = fill_px;
        rpt.cum_qty     = resting_book[i].qty;
        fills.insert(fills.size(), rpt);
      end else begin
        kept.insert(kept.size(), resting_book[i]);
      end
    end
    resting_book = kept;
    if (fills.size() > 0) fills[fills.size() - 1].last_of_run = 1'b1;
    if (fills.size() > widest_sweep) widest_sweep = fills.size();
    n_fills += fills.size();
    foreach (fills[i]) expected_reports.insert(expected_reports.size(), fills[i]);
  endfunction

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [31:0] near_price(logic [31:0] base, int unsigned spread);
    return base - spread + $urandom_range(0, 2 * spread);
  endfunction

  function automatic void add_order(logic [31:0] id, logic [15:0] sym, logic sd, logic ot,
                                    logic [31:0] px, logic [31:0] qty);
    feed_item_t it;
    it          = '0;
    it.kind     = KIND_ORDER;
    it.order_id = id;
    it.symbol   = sym;
    it.side     = sd;
    it.otype    = ot;
    it.price    = px;
    it.qty      = qty;
    it.bid      = $urandom;
    it.ask      = $urandom;
    pending_feed.insert(pending_feed.size(), it);
    feed_total++;
  endfunction

  function automatic void add_quote(logic [15:0] sym, logic [31:0] bid, logic [31:0] ask);
    feed_item_t it;
    it          = '0;
    it.kind     = KIND_QUOTE;
    it.order_id = $urandom;
    it.symbol   = sym;
    it.side     = $urandom_range(0, 1);
    it.otype    = $urandom_range(0, 1);
    it.price    = $urandom;
    it.qty      = $urandom;
    it.bid      = bid;
    it.ask      = ask;
    pending_feed.insert(pending_feed.size(), it);
    feed_total++;
  endfunction

  // Hold the feed until the book has answered everything sent so far.
  function automatic void add_pause();
    feed_item_t it;
    it       = '0;
    it.pause = 1'b1;
    pending_feed.insert(pending_feed.size(), it);
  endfunction

  // Driver
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_valid <= 1'b0;
      drive_item <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (feed_valid && !in_stall) book_step(drive_item);
      if (!feed_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          feed_valid <= 1'b0;
        end else if (pending_feed.size() == 0) begin
          feed_valid <= 1'b0;
        end else if (pending_feed[0].pause) begin
          feed_valid <= 1'b0;
          if (expected_reports.size() == 0) void'(pending_feed.pop_front());
        end else begin
          drive_item <= pending_feed.pop_front();
          feed_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            burst_left = 60;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // Monitor and report-side back pressure
  sink_mode_e sink_mode;
  int         mode_ticks;
  int         stall_run;
  logic       stall_on;

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      sink_stall <= 1'b0;
      sink_mode  = SINK_FREE;
      mode_ticks = 0;
      stall_run  = 0;
      stall_on   = 1'b0;
    end else begin
      if (report_valid && !sink_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, got order %h kind %0d", $time,
                   rpt_order_id, rpt_exec_kind);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_order_id", want.order_id, rpt_order_id);
          check_field("report_symbol", 32'(want.symbol), 32'(rpt_symbol));
          check_field("report_side", 32'(want.side), 32'(rpt_side));
          check_field("exec_kind", 32'(want.kind), 32'(rpt_exec_kind));
          check_field("last_qty", want.last_qty, rpt_last_qty);
          check_field("last_price", want.last_price, rpt_last_price);
          check_field("leaves_qty", want.leaves_qty, rpt_leaves_qty);
          check_field("cum_qty", want.cum_qty, rpt_cum_qty);
          check_field("avg_price", want.last_price, rpt_avg_price);
          check_field("last_of_run", 32'(want.last_of_run), 32'(rpt_last_of_run));
        end
      end
      mode_ticks++;
      if (mode_ticks >= 60) begin
        mode_ticks = 0;
        sink_mode  = sink_mode_e'($urandom_range(0, 3));
      end
      case (sink_mode)
        SINK_FREE:  sink_stall <= 1'b0;
        SINK_LIGHT: sink_stall <= ($urandom_range(0, 3) == 0);
        SINK_HEAVY: sink_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_run == 0) begin
            stall_on  = !stall_on;
            stall_run = $urandom_range(1, 8);
          end
          stall_run--;
          sink_stall <= stall_on;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests and %0d reports outstanding", $time,
               pending_feed.size(), expected_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] base;
    logic [15:0] sym;
    logic [15:0] pool[4];
    logic        sd;
    feed_item_t  raw;
    int          n;
    int          ep;
    int          roll;

    // Extremes, zero quantities, equal-price triggers, no-fill quotes.
    add_order(32'h0, 16'h0, SIDE_BUY, TYPE_MARKET, 32'h0, 32'h0);
    add_order(32'hFFFF_FFFF, 16'hFFFF, SIDE_SELL, TYPE_MARKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_order(32'h11, 16'd5, SIDE_BUY, TYPE_LIMIT, 32'hFFFF_FFFF, 32'd100);
    add_order(32'h12, 16'd5, SIDE_BUY, TYPE_LIMIT, 32'd1000, 32'd0);
    add_order(32'h13, 16'd5, SIDE_SELL, TYPE_LIMIT, 32'd1, 32'hFFFF_FFFF);
    add_order(32'h14, 16'd5, SIDE_SELL, TYPE_LIMIT, 32'd2000, 32'd7);
    add_order(32'h15, 16'hFFFF, SIDE_BUY, TYPE_LIMIT, 32'd500, 32'd3);
    add_quote(16'd5, 32'd0, 32'd0);
    add_quote(16'd6, 32'hFFFF_FFFF, 32'd1);
    add_quote(16'd5, 32'd0, 32'd1001);
    add_quote(16'd5, 32'd0, 32'd1000);
    add_quote(16'd5, 32'd1999, 32'd0);
    add_quote(16'd5, 32'd2000, 32'd0);
    add_quote(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_order(32'h16, 16'hFFFF, SIDE_SELL, TYPE_LIMIT, 32'hFFFF_FFFF, 32'd9);
    add_quote(16'hFFFF, 32'hFFFF_FFFF, 32'd500);
    add_order(32'h21, 16'd9, SIDE_BUY, TYPE_LIMIT, 32'd100, 32'd40);
    add_order(32'h22, 16'd9, SIDE_SELL, TYPE_LIMIT, 32'd50, 32'd41);
    add_order(32'h23, 16'd9, SIDE_BUY, TYPE_LIMIT, 32'd50, 32'd42);
    add_quote(16'd9, 32'd60, 32'd80);
    add_quote(16'd9, 32'd0, 32'd50);
    add_pause();

    // Overfill the book on one symbol, then sweep every resting order in one quote.
    sym  = $urandom;
    base = $urandom_range(20000, 32'hFFF0_0000);
    for (int i = 0; i < BOOK_DEPTH + 2; i++) begin
      sd = $urandom_range(0, 1);
      add_order($urandom, sym, sd, TYPE_LIMIT,
                (sd == SIDE_BUY) ? base + $urandom_range(0, 3000) : base - $urandom_range(0, 3000),
                $urandom);
    end
    add_quote(sym, base, base);
    add_pause();

    foreach (pool[p]) pool[p] = $urandom;
    ep = 0;
    while (feed_total < FEED_TARGET) begin
      base = $urandom_range(20000, 32'hFFF0_0000);
      n    = $urandom_range(2, 14);
      for (int k = 0; k < n; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          raw          = '0;
          raw.kind     = $urandom_range(0, 1);
          raw.order_id = $urandom;
          raw.symbol   = $urandom;
          raw.side     = $urandom_range(0, 1);
          raw.otype    = $urandom_range(0, 1);
          raw.price    = $urandom;
          raw.qty      = $urandom;
          raw.bid      = $urandom;
          raw.ask      = $urandom;
          if (raw.kind == KIND_ORDER && raw.otype == TYPE_LIMIT) begin
            stray_symbols.insert(stray_symbols.size(), raw.symbol);
          end
          pending_feed.insert(pending_feed.size(), raw);
          feed_total++;
        end else if (roll < 40) begin
          add_quote(pool[$urandom_range(0, 3)],
                    ($urandom_range(0, 5) == 0) ? 32'd0 : near_price(base, 5000),
                    ($urandom_range(0, 5) == 0) ? 32'd0 : near_price(base, 5000));
        end else begin
          add_order($urandom, pool[$urandom_range(0, 3)], $urandom_range(0, 1),
                    ($urandom_range(0, 4) == 0) ? TYPE_MARKET : TYPE_LIMIT,
                    near_price(base, 5000),
                    ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
        end
      end
      ep++;
      // Clear out resting orders now and then so the book does not stay full.
      if (ep % 5 == 0) begin
        foreach (pool[p]) add_quote(pool[p], 32'hFFFF_FFFF, 32'd1);
      end
      if (ep % 9 == 0) begin
        while (stray_symbols.size() != 0) add_quote(stray_symbols.pop_front(), 32'hFFFF_FFFF, 32'd1);
        add_pause();
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_feed.size() != 0 || feed_valid) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    $display("Ran %0d requests: %0d market, %0d limit, %0d quotes.", feed_total, n_market,
             n_limit, n_quotes);
    $display("Saw %0d acks, %0d fills, %0d rejects; book depth %0d, largest sweep %0d.",
             n_acks, n_fills, n_rejects, deepest_book, widest_sweep);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
